### sv/fixed_block_free_list_allocator_top_assert.svh
// Assertion macros for the fixed-block free-list allocator.
// Used by modules that have i_clk and i_rst_n in scope.
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset
`define FBFL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Condition in one cycle implies a condition in the next cycle
`define FBFL_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### sv/fbfl_pkg.sv
// Shared constants, types and helper functions for the free-list allocator.
// No dependencies.
package fbfl_pkg;

    localparam int MAX_BLOCKS      = 4096;
    localparam int IDX_W           = $clog2(MAX_BLOCKS);
    localparam int CNT_W           = IDX_W + 1;
    localparam int SIZE_W          = 13;
    localparam int ADDR_W          = 32;
    localparam int STAT_W          = 2;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int MAX_BLOCK_BYTES = 4096;
    localparam int MIN_BLOCK_BYTES = 8;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_ALLOC   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FREED   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_EXHAUST = 2'd3;

    // Request codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BLOCKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd2;

    // Configuration reset values
    localparam logic [SIZE_W-1:0] RST_BLOCK_BYTES = 13'd16;
    localparam logic [SIZE_W-1:0] RST_PAGE_BLOCKS = 13'd1024;
    localparam logic [ADDR_W-1:0] RST_POOL_BASE   = 32'd0;

    // One decided request on its way to the result stage
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              from_stack;  // index comes from the stack read port
        logic [IDX_W-1:0]  idx;         // fresh-page index, else zero
    } t_issue;

    // Requested size clamped to 8..4096 and rounded up to 8 bytes
    function automatic logic [SIZE_W-1:0] adj_bytes(input logic [SIZE_W-1:0] req);
        logic [SIZE_W-1:0] s;
        s = req;
        if (int'(s) > MAX_BLOCK_BYTES) s = SIZE_W'(MAX_BLOCK_BYTES);
        if (int'(s) < MIN_BLOCK_BYTES) s = SIZE_W'(MIN_BLOCK_BYTES);
        return SIZE_W'(s + SIZE_W'(7)) & ~SIZE_W'(7);
    endfunction

    // Page size with zero taken as one and clamped to the pool size
    function automatic logic [CNT_W-1:0] page_blocks(input logic [SIZE_W-1:0] req);
        logic [CNT_W-1:0] n;
        if (req == '0) begin
            n = CNT_W'(1);
        end else if (int'(req) > MAX_BLOCKS) begin
            n = CNT_W'(MAX_BLOCKS);
        end else begin
            n = CNT_W'(req);
        end
        return n;
    endfunction

endpackage

### sv/fbfl_ram.sv
// Simple dual-port RAM with registered read data; holds the freed-index stack.
// No dependencies.
module fbfl_ram #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [1 << ADDR_BITS];
    logic [DATA_BITS-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/fbfl_ctrl.sv
// Request decode and pool bookkeeping: stack depth and fresh-page pointers.
// Depends on fbfl_pkg and the assertion macro header.
`include "fixed_block_free_list_allocator_top_assert.svh"

module fbfl_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_func,
    input  logic                          i_free_present,
    input  logic [fbfl_pkg::IDX_W-1:0]    i_free_block_index,
    input  logic [fbfl_pkg::SIZE_W-1:0]   i_page_blocks,
    output logic                          o_issue_valid,
    output fbfl_pkg::t_issue              o_issue,
    input  logic                          i_issue_ready,
    output logic                          o_mem_we,
    output logic                          o_mem_re,
    output logic [fbfl_pkg::IDX_W-1:0]    o_mem_addr,
    output logic [fbfl_pkg::IDX_W-1:0]    o_mem_wdata
);
    import fbfl_pkg::*;

    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_fresh, n_fresh;
    logic [CNT_W-1:0] r_next,  n_next;
    logic [CNT_W-1:0] r_cur,   n_cur;
    logic [CNT_W-1:0] page_n;
    logic [CNT_W:0]   page_end;
    logic             accept;
    logic             push;
    logic             pop;
    t_issue           issue;

    assign o_ready = i_issue_ready && i_rst_n;
    assign accept  = i_valid && o_ready;

    // Decide one request against the current pool state
    always_comb begin
        n_count  = r_count;
        n_fresh  = r_fresh;
        n_next   = r_next;
        n_cur    = r_cur;
        push     = 1'b0;
        pop      = 1'b0;
        issue    = '0;
        page_n   = page_blocks(i_page_blocks);
        page_end = {1'b0, r_next} + {1'b0, page_n};
        if (i_func == FUNC_FREE) begin
            if (!i_free_present) begin
                issue.status = ST_NULL;
            end else begin
                issue.status = ST_FREED;
                // full stack drops the freed index silently; status still reads freed
                if (int'(r_count) < MAX_BLOCKS) begin
                    push    = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
        end else if (r_count != '0) begin
            issue.status     = ST_ALLOC;
            issue.from_stack = 1'b1;
            pop              = 1'b1;
            n_count          = r_count - CNT_W'(1);
        end else if (r_fresh != '0) begin
            issue.status = ST_ALLOC;
            issue.idx    = IDX_W'(r_cur + r_fresh - CNT_W'(1));
            n_fresh      = r_fresh - CNT_W'(1);
        end else if (int'(page_end) > MAX_BLOCKS) begin
            issue.status = ST_EXHAUST;
        end else begin
            // open a new page, hand out its top block
            issue.status = ST_ALLOC;
            issue.idx    = IDX_W'(page_end - (CNT_W+1)'(1));
            n_cur        = r_next;
            n_next       = CNT_W'(page_end);
            n_fresh      = page_n - CNT_W'(1);
        end
    end

    // Stack port: push writes at the depth, pop reads the top entry
    assign o_mem_we      = accept && push;
    assign o_mem_re      = accept && pop;
    assign o_mem_addr    = pop ? IDX_W'(r_count - CNT_W'(1)) : r_count[IDX_W-1:0];
    assign o_mem_wdata   = i_free_block_index;
    assign o_issue_valid = accept;
    assign o_issue       = issue;

    // Pool state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fresh <= '0;
            r_next  <= '0;
            r_cur   <= '0;
        end else if (accept) begin
            r_count <= n_count;
            r_fresh <= n_fresh;
            r_next  <= n_next;
            r_cur   <= n_cur;
        end
    end

    `FBFL_ASSERT_ALWAYS(a_count_max, int'(r_count) <= MAX_BLOCKS, "stack depth past pool size")
    `FBFL_ASSERT_ALWAYS(a_page_order, ({1'b0, r_cur} + {1'b0, r_fresh} <= {1'b0, r_next}) && (int'(r_next) <= MAX_BLOCKS), "fresh page pointers out of order")
    `FBFL_ASSERT_NEXT(a_pop_depth, o_mem_re, r_count == $past(r_count) - CNT_W'(1), "pop did not lower stack depth")

endmodule

### sv/fbfl_result.sv
// Result stage: joins the stack read data, forms the block address and
// holds the result beat in an output register. Depends on fbfl_pkg.
module fbfl_result (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_issue_valid,
    input  fbfl_pkg::t_issue              i_issue,
    output logic                          o_issue_ready,
    input  logic [fbfl_pkg::IDX_W-1:0]    i_rdata,
    input  logic [fbfl_pkg::SIZE_W-1:0]   i_req_bytes,
    input  logic [fbfl_pkg::ADDR_W-1:0]   i_pool_base,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [fbfl_pkg::STAT_W-1:0]   o_status,
    output logic [fbfl_pkg::IDX_W-1:0]    o_block_index,
    output logic [fbfl_pkg::ADDR_W-1:0]   o_block_address,
    output logic [fbfl_pkg::SIZE_W-1:0]   o_block_bytes
);
    import fbfl_pkg::*;

    localparam int PROD_W = IDX_W + SIZE_W;

    logic                r_s1_valid;
    t_issue              r_s1;
    logic                s1_adv;
    logic                r_out_valid;
    logic [STAT_W-1:0]   r_status;
    logic [IDX_W-1:0]    r_index;
    logic [ADDR_W-1:0]   r_address;
    logic [SIZE_W-1:0]   r_bytes;
    logic [IDX_W-1:0]    blk_idx;
    logic [SIZE_W-1:0]   blk_bytes;
    logic [PROD_W-1:0]   prod;
    logic [ADDR_W-1:0]   blk_addr;

    assign s1_adv        = r_s1_valid && (!r_out_valid || i_ready);
    assign o_issue_ready = !r_s1_valid || s1_adv;

    // Decided request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_issue_ready) begin
            r_s1_valid <= i_issue_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_issue_ready && i_issue_valid) begin
            r_s1 <= i_issue;
        end
    end

    // Index selection and address arithmetic
    always_comb begin
        blk_bytes = adj_bytes(i_req_bytes);
        blk_idx   = '0;
        blk_addr  = '0;
        if (r_s1.status == ST_ALLOC) begin
            blk_idx = r_s1.from_stack ? i_rdata : r_s1.idx;
        end
        prod = PROD_W'(blk_idx) * PROD_W'(blk_bytes);
        if (r_s1.status == ST_ALLOC) begin
            blk_addr = i_pool_base + ADDR_W'(prod);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_status  <= r_s1.status;
            r_index   <= blk_idx;
            r_address <= blk_addr;
            r_bytes   <= blk_bytes;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_block_index   = r_index;
    assign o_block_address = r_address;
    assign o_block_bytes   = r_bytes;

endmodule

### sv/fixed_block_free_list_allocator_top.sv
// Top level of the fixed-size block pool allocator with a LIFO free list.
// Depends on fbfl_pkg, fbfl_ctrl, fbfl_ram and fbfl_result.
//
// Usage:
//   Request channel (i_valid/o_ready) carries one allocate or free beat:
//   i_func selects allocate or free, i_free_present marks a non-null free,
//   i_free_block_index is the block being returned.
//   Result channel (o_valid/i_ready) returns one beat per request: status,
//   allocated index and byte address, and the adjusted block size.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data);
//   the user writes it only while no request is in flight; the block does not enforce this.
//   An accepted request waits in the decided-request register, then moves
//   to the output register when that is empty or being read. Throughput is
//   one request per cycle while i_ready stays high, set by the freed-index
//   stack RAM: one push or pop per request, pop data in the cycle after the address.
//   Reset clears the stack depth and page pointers and loads the register
//   defaults; the stack RAM itself needs no clearing, so requests are
//   taken from the first cycle after reset.
//   When the receiver holds i_ready low, one result waits in the output
//   register and one more in the decided-request stage, after which
//   o_ready drops until the result side moves again.
module fixed_block_free_list_allocator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_func,
    input  logic                              i_free_present,
    input  logic [fbfl_pkg::IDX_W-1:0]        i_free_block_index,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [fbfl_pkg::STAT_W-1:0]       o_status,
    output logic [fbfl_pkg::IDX_W-1:0]        o_block_index,
    output logic [fbfl_pkg::ADDR_W-1:0]       o_block_address,
    output logic [fbfl_pkg::SIZE_W-1:0]       o_block_bytes,
    input  logic                              i_cfg_we,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fbfl_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fbfl_pkg::*;

    logic [SIZE_W-1:0] r_req_bytes;
    logic [SIZE_W-1:0] r_page_blocks;
    logic [ADDR_W-1:0] r_pool_base;
    logic              issue_valid;
    logic              issue_ready;
    t_issue            issue;
    logic              mem_we;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_addr;
    logic [IDX_W-1:0]  mem_wdata;
    logic [IDX_W-1:0]  mem_rdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_bytes   <= RST_BLOCK_BYTES;
            r_page_blocks <= RST_PAGE_BLOCKS;
            r_pool_base   <= RST_POOL_BASE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BLOCK_BYTES: r_req_bytes   <= i_cfg_data[SIZE_W-1:0];
                CFG_PAGE_BLOCKS: r_page_blocks <= i_cfg_data[SIZE_W-1:0];
                CFG_POOL_BASE:   r_pool_base   <= i_cfg_data[ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    fbfl_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_func             (i_func),
        .i_free_present     (i_free_present),
        .i_free_block_index (i_free_block_index),
        .i_page_blocks      (r_page_blocks),
        .o_issue_valid      (issue_valid),
        .o_issue            (issue),
        .i_issue_ready      (issue_ready),
        .o_mem_we           (mem_we),
        .o_mem_re           (mem_re),
        .o_mem_addr         (mem_addr),
        .o_mem_wdata        (mem_wdata)
    );

    fbfl_ram #(
        .ADDR_BITS (IDX_W),
        .DATA_BITS (IDX_W)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_addr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_addr),
        .o_rdata (mem_rdata)
    );

    fbfl_result u_result (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_issue_valid   (issue_valid),
        .i_issue         (issue),
        .o_issue_ready   (issue_ready),
        .i_rdata         (mem_rdata),
        .i_req_bytes     (r_req_bytes),
        .i_pool_base     (r_pool_base),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_block_index   (o_block_index),
        .o_block_address (o_block_address),
        .o_block_bytes   (o_block_bytes)
    );

endmodule
